// ===== rtl/core/pbd_pkg.sv =====
package pbd_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  localparam int COMP_W  = 8;
  localparam int COLOR_W = 3 * COMP_W;
  localparam int SUM_W   = COMP_W + 2;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int DIST_W  = 20;
  localparam int RIDX_W  = 8;

  localparam logic [DIST_W-1:0] DIST_START = 20'd1000000;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [RIDX_W-1:0] idx;
  } pbd_scan_t;

endpackage

// ===== rtl/core/pbd_palette_ram.sv =====
module pbd_palette_ram
  import pbd_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COLOR_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/pbd_nearest.sv =====
module pbd_nearest
  import pbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pbd_scan_t          scan,
  input  logic [COLOR_W-1:0] color,
  input  logic [COMP_W-1:0]  mean_red,
  input  logic [COMP_W-1:0]  mean_green,
  input  logic [COMP_W-1:0]  mean_blue,
  output logic               done,
  output logic [RIDX_W-1:0]  best_index
);

  pbd_scan_t          s1_r;
  logic [SQ_W-1:0]    sq_r_r, sq_g_r, sq_b_r;
  logic [SQ_W-1:0]    sq_r_nxt, sq_g_nxt, sq_b_nxt;
  logic [DIST_W-1:0]  best_dist_r;
  logic [RIDX_W-1:0]  best_idx_r;
  logic               done_r;
  logic [DIST_W-1:0]  cand_dist;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                              input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  always_comb begin
    sq_r_nxt = sq_diff(mean_red,   color[3*COMP_W-1:2*COMP_W]);
    sq_g_nxt = sq_diff(mean_green, color[2*COMP_W-1:COMP_W]);
    sq_b_nxt = sq_diff(mean_blue,  color[COMP_W-1:0]);
  end

  assign cand_dist = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  always_ff @(posedge clk) begin
    sq_r_r <= sq_r_nxt;
    sq_g_r <= sq_g_nxt;
    sq_b_r <= sq_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld    <= 1'b0;
      done_r      <= 1'b0;
      best_dist_r <= DIST_START;
      best_idx_r  <= '0;
    end else begin
      s1_r.vld  <= scan.vld;
      s1_r.idx  <= scan.idx;
      s1_r.last <= scan.last;
      done_r    <= s1_r.vld && s1_r.last;
      if (start) begin
        best_dist_r <= DIST_START;
        best_idx_r  <= '0;
      end else if (s1_r.vld && (cand_dist < best_dist_r)) begin
        best_dist_r <= cand_dist;
        best_idx_r  <= s1_r.idx;
      end
    end
  end

  assign done       = done_r;
  assign best_index = best_idx_r;

endmodule

// ===== rtl/core/palette_box_downsample_nearest.sv =====
// palette write: taken while idle, no result
// filter item: up to 4 pixel reads, then a scan of all PALETTE_ENTRIES palette entries through
// the single palette read port, one per cycle; the next item is taken once the result is in
// the output register
// reset: control state and output valid clear; palette contents are kept, undefined until written
module palette_box_downsample_nearest
  import pbd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index, entry_red, entry_green, entry_blue, pixel_top_left, pixel_top_right,
  // pixel_bottom_left, pixel_bottom_right, right_column_present, bottom_row_present, zero pad
  input  logic [71:0] in_tdata,
  // operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_index
  output logic [7:0]  out_tdata
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GATHER = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [7:0]          pix_r [4];
  logic [2:0]          n_r, g_r;
  logic                rd_vld_r, rd_oob_r;
  logic [SUM_W-1:0]    sum_red_r, sum_green_r, sum_blue_r;
  logic [COMP_W-1:0]   mean_red_r, mean_green_r, mean_blue_r;
  logic [IDX_W-1:0]    s_r;
  pbd_scan_t           scan_r;
  logic                out_valid_r;
  logic [7:0]          out_data_r;

  logic                accept, wr_en, start, done, load_out, issue;
  logic [7:0]          pix_cur;
  logic [IDX_W-1:0]    rd_addr;
  logic [COLOR_W-1:0]  rd_data;
  logic [RIDX_W-1:0]   best_index;
  logic [1:0]          shift;
  logic                right, bottom;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign right     = in_tdata[64];
  assign bottom    = in_tdata[65];
  assign wr_en     = accept && (in_tuser == OP_WRITE)
                     && (9'(in_tdata[7:0]) < 9'(PALETTE_ENTRIES));

  assign pix_cur = pix_r[g_r[1:0]];
  assign issue   = (state_r == ST_GATHER) && (g_r < n_r);
  assign rd_addr = (state_r == ST_SCAN) ? s_r : pix_cur[IDX_W-1:0];
  assign start   = (state_r == ST_GATHER) && (g_r == n_r) && !rd_vld_r;
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  assign shift   = (n_r == 3'd4) ? 2'd2 : ((n_r == 3'd2) ? 2'd1 : 2'd0);

  pbd_palette_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_tdata[IDX_W-1:0]),
    .wr_data ({in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pbd_nearest u_nearest (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .scan       (scan_r),
    .color      (rd_data),
    .mean_red   (mean_red_r),
    .mean_green (mean_green_r),
    .mean_blue  (mean_blue_r),
    .done       (done),
    .best_index (best_index)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_tuser == OP_FILTER)) state_nxt = ST_GATHER;
      end
      ST_GATHER: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (s_r == IDX_W'(PALETTE_ENTRIES - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // item fields, running sums, means and the result register
  always_ff @(posedge clk) begin
    if (accept && (in_tuser == OP_FILTER)) begin
      pix_r[0] <= in_tdata[39:32];
      pix_r[1] <= right ? in_tdata[47:40] : in_tdata[55:48];
      pix_r[2] <= in_tdata[55:48];
      pix_r[3] <= in_tdata[63:56];
      n_r      <= 3'd1 + 3'(right) + 3'(bottom) + 3'(right && bottom);
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
    end else if (rd_vld_r && !rd_oob_r) begin
      sum_red_r   <= sum_red_r   + SUM_W'(rd_data[23:16]);
      sum_green_r <= sum_green_r + SUM_W'(rd_data[15:8]);
      sum_blue_r  <= sum_blue_r  + SUM_W'(rd_data[7:0]);
    end
    if (start) begin
      mean_red_r   <= COMP_W'(sum_red_r   >> shift);
      mean_green_r <= COMP_W'(sum_green_r >> shift);
      mean_blue_r  <= COMP_W'(sum_blue_r  >> shift);
    end
    rd_oob_r    <= !(9'(pix_cur) < 9'(PALETTE_ENTRIES));
    if (load_out) begin
      out_data_r <= best_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      g_r         <= '0;
      s_r         <= '0;
      rd_vld_r    <= 1'b0;
      scan_r.vld  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= issue;
      scan_r.vld  <= (state_r == ST_SCAN);
      scan_r.idx  <= RIDX_W'(s_r);
      scan_r.last <= (s_r == IDX_W'(PALETTE_ENTRIES - 1));
      if (accept) begin
        g_r <= '0;
      end else if (issue) begin
        g_r <= g_r + 3'd1;
      end
      if (start) begin
        s_r <= '0;
      end else if (state_r == ST_SCAN) begin
        s_r <= s_r + IDX_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATHER) |-> (g_r <= n_r))
    else $error("pixel reads beyond count");

  a_scan_source: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.vld |-> ($past(state_r) == ST_SCAN))
    else $error("scan entry outside scan");

  a_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (state_r == ST_DRAIN))
    else $error("search done outside drain");

endmodule

// ===== sim/nearest_index_checker.sv =====
module nearest_index_checker
  import pbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // entry_index, entry_red, entry_green, entry_blue, pixel_top_left, pixel_top_right,
  // pixel_bottom_left, pixel_bottom_right, right_column_present, bottom_row_present, zero pad
  input  logic [71:0] in_tdata,
  // operation
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // result_index
  input  logic [7:0]  out_tdata,
  output int          fail_count,
  output int          pending_count
);

  localparam int PAL_SIZE = 256;

  logic [COLOR_W-1:0] palette_copy [PAL_SIZE];
  logic [RIDX_W-1:0]  expected_index_q [$];

  function automatic logic [RIDX_W-1:0] nearest_palette_index(input logic [71:0] d);
    logic [COLOR_W-1:0] px [4];
    logic [RIDX_W-1:0]  best;
    int n;
    int i;
    int shift;
    int sum_r, sum_g, sum_b;
    int dr, dg, db, cand_dist, best_dist;
    n = 0;
    px[n] = palette_copy[d[39:32]];
    n++;
    if (d[64]) begin
      px[n] = palette_copy[d[47:40]];
      n++;
    end
    if (d[65]) begin
      px[n] = palette_copy[d[55:48]];
      n++;
    end
    if (d[64] && d[65]) begin
      px[n] = palette_copy[d[63:56]];
      n++;
    end
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (i = 0; i < n; i++) begin
      sum_r += int'(px[i][23:16]);
      sum_g += int'(px[i][15:8]);
      sum_b += int'(px[i][7:0]);
    end
    shift = (n == 4) ? 2 : ((n == 2) ? 1 : 0);
    sum_r = sum_r >> shift;
    sum_g = sum_g >> shift;
    sum_b = sum_b >> shift;
    // first entry with the least distance wins
    best = '0;
    best_dist = int'(DIST_START);
    for (i = 0; i < PAL_SIZE; i++) begin
      dr = sum_r - int'(palette_copy[i][23:16]);
      dg = sum_g - int'(palette_copy[i][15:8]);
      db = sum_b - int'(palette_copy[i][7:0]);
      cand_dist = dr * dr + dg * dg + db * db;
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best = RIDX_W'(i);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_index_q.size() == 0) begin
          $error("result_index: no item waiting, actual %0d", out_tdata);
          fail_count++;
        end else begin
          if (out_tdata !== expected_index_q[0]) begin
            $error("result_index mismatch: expected %0d, actual %0d",
                   expected_index_q[0], out_tdata);
            fail_count++;
          end
          void'(expected_index_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE) begin
          palette_copy[in_tdata[7:0]] = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
        end else begin
          expected_index_q = {expected_index_q, nearest_palette_index(in_tdata)};
        end
      end
      pending_count = expected_index_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import pbd_pkg::*;

  localparam int PAL_SIZE     = 256;
  localparam int RANDOM_ITEMS = 1475;
  localparam int SEGMENT      = 250;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 3000000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic        in_tuser   = OP_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;

  bit idle_en    = 1'b0;
  int stall_left = 0;
  int cycles     = 0;
  int fails;
  int pending;

  palette_box_downsample_nearest i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  nearest_index_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fails),
    .pending_count (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!idle_en) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] coarse_level();
    return 8'(85 * $urandom_range(0, 3));
  endfunction

  task automatic send_item(input logic op, input logic [71:0] d);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    logic [71:0] d;
    d = '0;
    d[65:32] = 34'({$urandom, $urandom});
    d[7:0]   = idx;
    d[15:8]  = r;
    d[23:16] = g;
    d[31:24] = b;
    send_item(OP_WRITE, d);
  endtask

  task automatic filter_block(input logic [7:0] tl, input logic [7:0] tr,
                              input logic [7:0] bl, input logic [7:0] br,
                              input logic right, input logic bottom);
    logic [71:0] d;
    d = '0;
    d[31:0]  = $urandom;
    d[39:32] = tl;
    d[47:40] = tr;
    d[55:48] = bl;
    d[63:56] = br;
    d[64]    = right;
    d[65]    = bottom;
    send_item(OP_FILTER, d);
  endtask

  initial begin
    int  k;
    logic coarse;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // full palette load, odd slots on a coarse grid so equal colors occur
    idle_en = 1'b1;
    for (k = 0; k < PAL_SIZE; k++) begin
      if (k == 0) begin
        write_entry(8'h00, 8'h00, 8'h00, 8'h00);
      end else if (k == PAL_SIZE - 1) begin
        write_entry(8'hff, 8'hff, 8'hff, 8'hff);
      end else if (k == 10 || k == 20) begin
        write_entry(8'(k), 8'd128, 8'd64, 8'd32);
      end else if (k % 2 == 1) begin
        write_entry(8'(k), coarse_level(), coarse_level(), coarse_level());
      end else begin
        write_entry(8'(k), rand_byte(), rand_byte(), rand_byte());
      end
    end

    // directed blocks
    idle_en = 1'b0;
    filter_block(8'h00, rand_byte(), rand_byte(), rand_byte(), 1'b0, 1'b0);
    filter_block(8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    filter_block(8'd20, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0);
    filter_block(8'h00, 8'hff, 8'h00, 8'h00, 1'b1, 1'b0);
    filter_block(8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 1'b1);
    filter_block(8'h00, 8'hff, 8'hff, 8'h00, 1'b1, 1'b1);
    filter_block(8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1);
    filter_block(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    filter_block(8'd10, 8'd20, 8'd20, 8'd10, 1'b1, 1'b1);
    // equal colors at both ends of the palette
    write_entry(8'hff, 8'h00, 8'h00, 8'h00);
    filter_block(8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    write_entry(8'h00, 8'hff, 8'hff, 8'hff);
    filter_block(8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1);
    write_entry(8'h00, 8'h00, 8'h00, 8'h00);
    write_entry(8'hff, 8'hff, 8'hff, 8'hff);
    // odd sums truncate
    write_entry(8'd1, 8'hff, 8'hff, 8'hff);
    write_entry(8'd2, 8'h00, 8'h01, 8'hfe);
    filter_block(8'd1, 8'd2, 8'h00, 8'h00, 1'b1, 1'b0);
    filter_block(8'd1, 8'd2, 8'd2, 8'd2, 1'b1, 1'b1);

    // random traffic, quiet last segment
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % SEGMENT == 0) begin
        idle_en = (k >= RANDOM_ITEMS - SEGMENT) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 30) begin
        coarse = 1'($urandom_range(0, 1));
        write_entry(rand_byte(),
                    coarse ? coarse_level() : rand_byte(),
                    coarse ? coarse_level() : rand_byte(),
                    coarse ? coarse_level() : rand_byte());
      end else begin
        filter_block(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pbd_pkg.sv
rtl/core/pbd_palette_ram.sv
rtl/core/pbd_nearest.sv
rtl/core/palette_box_downsample_nearest.sv
sim/nearest_index_checker.sv
sim/tb.sv
